>>> design/gradient_optimizer_update_core_macros.svh
// Assertion macros for the optimizer update core
`ifndef GRADIENT_OPTIMIZER_UPDATE_CORE_MACROS_SVH
`define GRADIENT_OPTIMIZER_UPDATE_CORE_MACROS_SVH

`ifndef SYNTH
// checked property, off while reset is asserted
`define OGU_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("ogu assertion failed");
// checked property, also during reset
`define OGU_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("ogu assertion failed");
`else
`define OGU_ASSERT(lbl, clk, rstn, prop)
`define OGU_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> design/ogu_pkg.sv
package ogu_pkg;

  localparam int OGU_FRAC_BITS_DEF = 24;

  // update rule codes
  localparam logic [1:0] MODE_SGD = 2'd0;
  localparam logic [1:0] MODE_MOM = 2'd1;
  localparam logic [1:0] MODE_RMS = 2'd2;

  // request op codes
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_DECAY  = 1'b1;

  // configuration register indexes
  localparam logic [2:0] CFG_MODE     = 3'd0;
  localparam logic [2:0] CFG_LR       = 3'd1;
  localparam logic [2:0] CFG_MU       = 3'd2;
  localparam logic [2:0] CFG_RHO      = 3'd3;
  localparam logic [2:0] CFG_DECAY    = 3'd4;
  localparam logic [2:0] CFG_DECAY_EN = 3'd5;

  // register reset values
  localparam logic [1:0]  MODE_RST  = MODE_SGD;
  localparam logic [23:0] LR_RST    = 24'd16777;
  localparam logic [15:0] MU_RST    = 16'd58982;
  localparam logic [15:0] RHO_RST   = 16'd64880;
  localparam logic [15:0] DECAY_RST = 16'd65535;

  typedef struct packed {
    logic               op;
    logic signed [31:0] param_word;
    logic signed [31:0] grad_value;
    logic signed [31:0] cache_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] new_param;
    logic signed [31:0] new_cache;
  } out_item_t;

  // per-element data carried alongside the root and divide pipes
  typedef struct packed {
    logic signed [31:0] p;        // parameter in
    logic signed [31:0] nc;       // new cache
    logic signed [32:0] step_nr;  // step for sgd and momentum
    logic               tneg;     // sign of the rmsprop numerator
    logic [31:0]        mag;      // magnitude of the rmsprop numerator
    logic               rms;      // rmsprop element
  } front_side_t;

  // saturate to the 32-bit signed range
  function automatic logic signed [31:0] sat32(input logic signed [71:0] x);
    logic signed [71:0] hi;
    logic signed [71:0] lo;
    hi = 72'sh7FFF_FFFF;
    lo = -72'sh8000_0000;
    if (x > hi) return 32'sh7FFF_FFFF;
    if (x < lo) return 32'sh8000_0000;
    return x[31:0];
  endfunction

endpackage

>>> design/ogu_front.sv
module ogu_front #(
  parameter int FRAC_BITS = ogu_pkg::OGU_FRAC_BITS_DEF,
  parameter int VW        = 32 + ogu_pkg::OGU_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_vld,
  input  ogu_pkg::in_item_t     in_item,
  input  logic [23:0]           lr,
  input  logic [1:0]            mode,
  input  logic [15:0]           mu,
  input  logic [15:0]           rho,
  output logic                  out_vld,
  output logic [VW-1:0]         out_rad,
  output ogu_pkg::front_side_t  out_side
);
  import ogu_pkg::*;

  logic [6:1] v_r;

  // stage 1: capture
  logic signed [31:0] p1_r, g1_r, c1_r;
  logic [23:0]        lr1_r;
  // stage 2: products
  logic signed [31:0] p2_r, g2_r, c2_r;
  logic [23:0]        lr2_r;
  logic signed [56:0] plg2_r;
  logic signed [48:0] pcc2_r;
  logic [63:0]        gg2_r;
  // stage 3: rounding
  logic signed [31:0] p3_r, g3_r, c3_r;
  logic [23:0]        lr3_r;
  logic signed [32:0] t3_r, mc3_r;
  logic [30:0]        gsq3_r;
  // stage 4: momentum cache, rmsprop second product
  logic signed [31:0] p4_r, c4_r, ncm4_r;
  logic [23:0]        lr4_r;
  logic signed [32:0] t4_r, mc4_r;
  logic [47:0]        pr4_r;
  // stage 5: cache select, momentum step product
  logic signed [31:0] p5_r, nc5_r;
  logic signed [32:0] t5_r;
  logic signed [56:0] pm5_r;
  // stage 6 outputs
  logic [VW-1:0]      rad6_r;
  front_side_t        side6_r;

  logic signed [56:0] tr, pmr;
  logic signed [48:0] mr;
  logic [64:0]        gs, gsh;
  logic [47:0]        prr;
  logic signed [31:0] ncr, ncsel, cpos;
  logic signed [32:0] tabs, step_m;
  logic [15:0]        coef;

  assign coef = (mode == MODE_RMS) ? rho : mu;

  // combinational pieces between registers
  always_comb begin
    tr     = plg2_r + (57'sd1 <<< 23);
    mr     = pcc2_r + (49'sd1 <<< 15);
    gs     = {1'b0, gg2_r} + (65'd1 << (FRAC_BITS - 1));
    gsh    = gs >> FRAC_BITS;
    prr    = pr4_r + 48'h8000;
    ncr    = sat32(72'(mc4_r) + 72'($signed({1'b0, prr[47:16]})));
    pmr    = pm5_r + (57'sd1 <<< 23);
    step_m = pmr[56:24];
    tabs   = t5_r[32] ? -t5_r : t5_r;
    cpos   = nc5_r[31] ? 32'sd0 : nc5_r;
    case (mode)
      MODE_MOM: ncsel = ncm4_r;
      MODE_RMS: ncsel = ncr;
      default:  ncsel = c4_r;
    endcase
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[5:1], in_vld && (in_item.op == OP_UPDATE)};
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (en) begin
      p1_r  <= in_item.param_word;
      g1_r  <= in_item.grad_value;
      c1_r  <= in_item.cache_value;
      lr1_r <= lr;

      p2_r   <= p1_r;
      g2_r   <= g1_r;
      c2_r   <= c1_r;
      lr2_r  <= lr1_r;
      plg2_r <= 57'($signed({1'b0, lr1_r})) * 57'(g1_r);
      pcc2_r <= 49'($signed({1'b0, coef})) * 49'(c1_r);
      gg2_r  <= 64'(64'(g1_r) * 64'(g1_r));

      p3_r   <= p2_r;
      g3_r   <= g2_r;
      c3_r   <= c2_r;
      lr3_r  <= lr2_r;
      t3_r   <= tr[56:24];
      mc3_r  <= mr[48:16];
      gsq3_r <= (gsh > 65'h7FFF_FFFF) ? 31'h7FFF_FFFF : gsh[30:0];

      p4_r   <= p3_r;
      c4_r   <= c3_r;
      lr4_r  <= lr3_r;
      t4_r   <= t3_r;
      mc4_r  <= mc3_r;
      ncm4_r <= sat32(72'(mc3_r) + 72'(g3_r));
      pr4_r  <= 48'(gsq3_r) * 48'(17'h10000 - 17'(rho));

      p5_r  <= p4_r;
      t5_r  <= t4_r;
      nc5_r <= ncsel;
      pm5_r <= 57'($signed({1'b0, lr4_r})) * 57'(ncm4_r);

      rad6_r          <= VW'(32'(cpos) + 32'd1) << FRAC_BITS;
      side6_r.p       <= p5_r;
      side6_r.nc      <= nc5_r;
      side6_r.step_nr <= (mode == MODE_MOM) ? step_m : t5_r;
      side6_r.tneg    <= t5_r[32];
      side6_r.mag     <= tabs[31:0];
      side6_r.rms     <= (mode == MODE_RMS);
    end
  end

  assign out_vld  = v_r[6];
  assign out_rad  = rad6_r;
  assign out_side = side6_r;

endmodule

>>> design/ogu_sqrt.sv
module ogu_sqrt #(
  parameter int VW = 32 + ogu_pkg::OGU_FRAC_BITS_DEF,
  parameter int SW = $bits(ogu_pkg::front_side_t),
  parameter int RW = (VW + 1) / 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  logic [VW-1:0] in_val,
  input  logic [SW-1:0] in_side,
  output logic          out_vld,
  output logic [RW-1:0] out_root,
  output logic [SW-1:0] out_side
);
  import ogu_pkg::*;

  localparam int TW = 2 * RW + 1;

  logic [TW-1:0] rem_r  [RW];
  logic [RW-1:0] root_r [RW];
  logic [SW-1:0] side_r [RW];
  logic [RW-1:0] vld_r;

  // one root bit per stage, most significant first
  for (genvar i = 0; i < RW; i++) begin : g_stage
    localparam int K = RW - 1 - i;
    logic [TW-1:0] rem_in, trial;
    logic [RW-1:0] root_in;
    logic [SW-1:0] side_in;
    logic          vld_in;

    if (i == 0) begin : g_first
      assign rem_in  = TW'(in_val);
      assign root_in = '0;
      assign side_in = in_side;
      assign vld_in  = in_vld;
    end else begin : g_next
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign side_in = side_r[i-1];
      assign vld_in  = vld_r[i-1];
    end

    // (r + 2^K)^2 - r^2
    assign trial = (TW'(root_in) << (K + 1)) + (TW'(1) << (2 * K));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[i] <= side_in;
        if (rem_in >= trial) begin
          rem_r[i]  <= rem_in - trial;
          root_r[i] <= root_in | (RW'(1) << K);
        end else begin
          rem_r[i]  <= rem_in;
          root_r[i] <= root_in;
        end
      end
    end
  end

  assign out_vld  = vld_r[RW-1];
  assign out_root = root_r[RW-1];
  assign out_side = side_r[RW-1];

endmodule

>>> design/ogu_div.sv
module ogu_div #(
  parameter int NW  = 33 + ogu_pkg::OGU_FRAC_BITS_DEF,
  parameter int DVW = (33 + ogu_pkg::OGU_FRAC_BITS_DEF) / 2,
  parameter int SW  = $bits(ogu_pkg::front_side_t)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_vld,
  input  logic [NW-1:0]  in_num,
  input  logic [DVW-1:0] in_den,
  input  logic [SW-1:0]  in_side,
  output logic           out_vld,
  output logic [NW-1:0]  out_quo,
  output logic [SW-1:0]  out_side
);
  import ogu_pkg::*;

  localparam int CW = NW + DVW;

  logic [NW-1:0]  rem_r [NW];
  logic [NW-1:0]  quo_r [NW];
  logic [DVW-1:0] den_r [NW];
  logic [SW-1:0]  side_r [NW];
  logic [NW-1:0]  vld_r;

  // restoring divide, one quotient bit per stage
  for (genvar i = 0; i < NW; i++) begin : g_stage
    localparam int K = NW - 1 - i;
    logic [NW-1:0]  rem_in, quo_in;
    logic [DVW-1:0] den_in;
    logic [SW-1:0]  side_in;
    logic           vld_in;
    logic [CW-1:0]  dsh;

    if (i == 0) begin : g_first
      assign rem_in  = in_num;
      assign quo_in  = '0;
      assign den_in  = in_den;
      assign side_in = in_side;
      assign vld_in  = in_vld;
    end else begin : g_next
      assign rem_in  = rem_r[i-1];
      assign quo_in  = quo_r[i-1];
      assign den_in  = den_r[i-1];
      assign side_in = side_r[i-1];
      assign vld_in  = vld_r[i-1];
    end

    assign dsh = CW'(den_in) << K;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[i]  <= den_in;
        side_r[i] <= side_in;
        if (CW'(rem_in) >= dsh) begin
          rem_r[i] <= rem_in - dsh[NW-1:0];
          quo_r[i] <= quo_in | (NW'(1) << K);
        end else begin
          rem_r[i] <= rem_in;
          quo_r[i] <= quo_in;
        end
      end
    end
  end

  assign out_vld  = vld_r[NW-1];
  assign out_quo  = quo_r[NW-1];
  assign out_side = side_r[NW-1];

endmodule

>>> design/gradient_optimizer_update_core.sv
// Optimizer update core: one parameter element (parameter, gradient, cache)
// per request, returning the updated parameter and cache in sgd, momentum
// or rmsprop mode, all in signed fixed point with FRAC_BITS fraction bits.
// Throughput is one request per cycle; a stall on the output freezes the
// whole pipe of 6 front stages, (FRAC_BITS+33)/2 square-root stages (one
// root bit each), one divide setup stage, FRAC_BITS+33 divide stages (one
// quotient bit each) and the output register. Decay requests only scale the
// running learning rate on acceptance, if decay is enabled, and produce no
// result; a learning-rate write reloads the running rate. Configuration must
// be written by the user only while the core is idle; it is not enforced.
module gradient_optimizer_update_core #(
  parameter int FRAC_BITS = ogu_pkg::OGU_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ogu_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ogu_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_wdata
);
  import ogu_pkg::*;

  `include "gradient_optimizer_update_core_macros.svh"

  localparam int VW = 32 + FRAC_BITS;
  localparam int RW = (VW + 1) / 2;
  localparam int NW = 33 + FRAC_BITS;
  localparam int SW = $bits(front_side_t);
  localparam int SX = NW + 2;

  logic [1:0]  mode_r;
  logic [23:0] lr_r, rr_r;
  logic [15:0] mu_r, rho_r, decay_r;
  logic        decay_en_r;

  logic        en, in_acc;
  logic [39:0] rr_prod;

  assign in_stall = out_valid && out_stall;
  assign en       = !in_stall;
  assign in_acc   = in_valid && en;
  assign rr_prod  = 40'(rr_r) * 40'(decay_r) + 40'h8000;

  // configuration registers and running learning rate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_RST;
      lr_r       <= LR_RST;
      rr_r       <= LR_RST;
      mu_r       <= MU_RST;
      rho_r      <= RHO_RST;
      decay_r    <= DECAY_RST;
      decay_en_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MODE:     mode_r     <= cfg_wdata[1:0];
          CFG_LR: begin
            lr_r <= cfg_wdata;
            rr_r <= cfg_wdata;
          end
          CFG_MU:       mu_r       <= cfg_wdata[15:0];
          CFG_RHO:      rho_r      <= cfg_wdata[15:0];
          CFG_DECAY:    decay_r    <= cfg_wdata[15:0];
          CFG_DECAY_EN: decay_en_r <= cfg_wdata[0];
          default: ;
        endcase
      end else if (in_acc && (in_data.op == OP_DECAY) && decay_en_r) begin
        rr_r <= rr_prod[39:16];
      end
    end
  end

  // front arithmetic
  logic          f_vld;
  logic [VW-1:0] f_rad;
  front_side_t   f_side;

  ogu_front #(.FRAC_BITS(FRAC_BITS), .VW(VW)) u_front (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(in_acc), .in_item(in_data),
    .lr(rr_r), .mode(mode_r), .mu(mu_r), .rho(rho_r),
    .out_vld(f_vld), .out_rad(f_rad), .out_side(f_side)
  );

  // square root
  logic          s_vld;
  logic [RW-1:0] s_root;
  logic [SW-1:0] s_side;
  front_side_t   s_sd;

  ogu_sqrt #(.VW(VW), .SW(SW), .RW(RW)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(f_vld), .in_val(f_rad), .in_side(f_side),
    .out_vld(s_vld), .out_root(s_root), .out_side(s_side)
  );

  assign s_sd = s_side;

  // divide setup: rounded dividend
  logic          dp_vld_r;
  logic [NW-1:0] dp_num_r;
  logic [RW-1:0] dp_den_r;
  logic [SW-1:0] dp_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dp_vld_r <= 1'b0;
    end else if (en) begin
      dp_vld_r <= s_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dp_num_r  <= (NW'(s_sd.mag) << FRAC_BITS) + NW'(s_root >> 1);
      dp_den_r  <= s_root;
      dp_side_r <= s_side;
    end
  end

  // divide
  logic          d_vld;
  logic [NW-1:0] d_quo;
  logic [SW-1:0] d_side;
  front_side_t   d_sd;

  ogu_div #(.NW(NW), .DVW(RW), .SW(SW)) u_div (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(dp_vld_r), .in_num(dp_num_r), .in_den(dp_den_r), .in_side(dp_side_r),
    .out_vld(d_vld), .out_quo(d_quo), .out_side(d_side)
  );

  assign d_sd = d_side;

  // final subtract and saturate into the output register
  logic signed [SX-1:0] qs, stepx, diff;
  logic signed [71:0]   diffx;

  always_comb begin
    qs    = $signed({2'b00, d_quo});
    if (d_sd.rms) begin
      stepx = d_sd.tneg ? -qs : qs;
    end else begin
      stepx = SX'(d_sd.step_nr);
    end
    diff  = SX'(d_sd.p) - stepx;
    diffx = 72'(diff);
  end

  logic      out_vld_r;
  out_item_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r.new_param <= sat32(diffx);
      out_r.new_cache <= d_sd.nc;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // checks
  `OGU_ASSERT_ALWAYS(a_rst_no_out, clk, !rst_n |=> !out_valid)
  `OGU_ASSERT(a_lr_reload, clk, rst_n,
    (cfg_we && cfg_index == CFG_LR) |=> (rr_r == $past(cfg_wdata)))
  `OGU_ASSERT(a_decay_off, clk, rst_n,
    (in_acc && in_data.op == OP_DECAY && !decay_en_r && !cfg_we) |=> $stable(rr_r))
  `OGU_ASSERT(a_stall_freeze, clk, rst_n,
    (out_valid && out_stall) |=> ($stable(d_vld) && $stable(dp_vld_r)))

endmodule
